FILE: sv/srht_pkg.sv
// ----------------------------------------------------------------------------
// srht_pkg
// Shared constants, register indexes and the flag struct for the segment
// rectangle hit test core.
// ----------------------------------------------------------------------------
package srht_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_CORNER_A_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_A_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_B_X = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_B_Y = 2'd3;

  typedef struct packed {
    logic in_rect;
    logic vert;
    logic vert_hit;
    logic xmin_span;
    logic xmax_span;
    logic ymin_span;
    logic ymax_span;
    logic dy_nz;
  } flags_t;

endpackage

FILE: sv/srht_seg_if.sv
// ----------------------------------------------------------------------------
// srht_seg_if
// Segment request channel: two endpoints with valid/ready.
// ----------------------------------------------------------------------------
interface srht_seg_if #(
  parameter int W = srht_pkg::COORD_WIDTH
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] start_x;
  logic signed [W-1:0] start_y;
  logic signed [W-1:0] end_x;
  logic signed [W-1:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

FILE: sv/srht_hit_if.sv
// ----------------------------------------------------------------------------
// srht_hit_if
// Result channel: one hit bit per request with valid/ready.
// ----------------------------------------------------------------------------
interface srht_hit_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink   (input valid, hit, output ready);
endinterface

FILE: sv/srht_cfg_if.sv
// ----------------------------------------------------------------------------
// srht_cfg_if
// Configuration write channel: register index and data with valid/ready.
// ----------------------------------------------------------------------------
interface srht_cfg_if #(
  parameter int W = srht_pkg::COORD_WIDTH
);
  logic                              valid;
  logic                              ready;
  logic [srht_pkg::CFG_IDX_W-1:0]    index;
  logic [W-1:0]                      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/srht_prep.sv
// ----------------------------------------------------------------------------
// srht_prep
// Orders the endpoints by x, forms the edge offsets and the span and
// endpoint flags for one segment.
// ----------------------------------------------------------------------------
module srht_prep #(
  parameter int W = srht_pkg::COORD_WIDTH
) (
  input  logic signed [W-1:0]   x0,
  input  logic signed [W-1:0]   y0,
  input  logic signed [W-1:0]   x1,
  input  logic signed [W-1:0]   y1,
  input  logic signed [W-1:0]   xmin,
  input  logic signed [W-1:0]   xmax,
  input  logic signed [W-1:0]   ymin,
  input  logic signed [W-1:0]   ymax,
  output logic signed [W+1:0]   d,
  output logic signed [W+1:0]   dy,
  output logic signed [W+1:0]   a,
  output logic signed [W+1:0]   b,
  output logic signed [W+1:0]   tmin,
  output logic signed [W+1:0]   tmax,
  output logic signed [W+1:0]   ady,
  output logic signed [W+1:0]   umin,
  output logic signed [W+1:0]   umax,
  output srht_pkg::flags_t      flags
);
  localparam int OW = W + 2;

  logic                swap;
  logic signed [W-1:0] lx0, ly0, lx1, ly1;
  logic signed [W-1:0] oy_lo, oy_hi, ly_lo, ly_hi;
  logic                dy_neg;

  assign swap = x1 < x0;
  assign lx0  = swap ? x1 : x0;
  assign ly0  = swap ? y1 : y0;
  assign lx1  = swap ? x0 : x1;
  assign ly1  = swap ? y0 : y1;

  assign d    = OW'(lx1) - OW'(lx0);
  assign dy   = OW'(ly1) - OW'(ly0);
  assign a    = OW'(ymin) - OW'(ly0);
  assign b    = OW'(ymax) - OW'(ly0);
  assign tmin = OW'(xmin) - OW'(lx0);
  assign tmax = OW'(xmax) - OW'(lx0);

  assign dy_neg = dy[OW-1];
  assign ady    = dy_neg ? -dy : dy;
  assign umin   = dy_neg ? -a : a;
  assign umax   = dy_neg ? -b : b;

  assign oy_lo = (y0 < y1) ? y0 : y1;
  assign oy_hi = (y0 < y1) ? y1 : y0;
  assign ly_lo = (ly0 < ly1) ? ly0 : ly1;
  assign ly_hi = (ly0 < ly1) ? ly1 : ly0;

  assign flags.in_rect   = (x0 >= xmin && x0 <= xmax && y0 >= ymin && y0 <= ymax) ||
                           (x1 >= xmin && x1 <= xmax && y1 >= ymin && y1 <= ymax);
  assign flags.vert      = x0 == x1;
  assign flags.vert_hit  = x0 > xmin && x0 < xmax && oy_lo <= ymax && oy_hi >= ymin;
  assign flags.xmin_span = xmin >= lx0 && xmin <= lx1;
  assign flags.xmax_span = xmax >= lx0 && xmax <= lx1;
  assign flags.ymin_span = ymin >= ly_lo && ymin <= ly_hi;
  assign flags.ymax_span = ymax >= ly_lo && ymax <= ly_hi;
  assign flags.dy_nz     = ly0 != ly1;

endmodule

FILE: sv/srht_prod.sv
// ----------------------------------------------------------------------------
// srht_prod
// Forms the eight cross products used by the edge crossing tests.
// ----------------------------------------------------------------------------
module srht_prod #(
  parameter int W = srht_pkg::COORD_WIDTH
) (
  input  logic signed [W+1:0]       d,
  input  logic signed [W+1:0]       dy,
  input  logic signed [W+1:0]       a,
  input  logic signed [W+1:0]       b,
  input  logic signed [W+1:0]       tmin,
  input  logic signed [W+1:0]       tmax,
  input  logic signed [W+1:0]       ady,
  input  logic signed [W+1:0]       umin,
  input  logic signed [W+1:0]       umax,
  output logic signed [2*W+3:0]     p_ad,
  output logic signed [2*W+3:0]     p_bd,
  output logic signed [2*W+3:0]     p_dy_tmin,
  output logic signed [2*W+3:0]     p_dy_tmax,
  output logic signed [2*W+3:0]     p_tmin_ady,
  output logic signed [2*W+3:0]     p_tmax_ady,
  output logic signed [2*W+3:0]     p_umin_d,
  output logic signed [2*W+3:0]     p_umax_d
);
  localparam int PW = 2 * W + 4;

  assign p_ad       = PW'(a)    * PW'(d);
  assign p_bd       = PW'(b)    * PW'(d);
  assign p_dy_tmin  = PW'(dy)   * PW'(tmin);
  assign p_dy_tmax  = PW'(dy)   * PW'(tmax);
  assign p_tmin_ady = PW'(tmin) * PW'(ady);
  assign p_tmax_ady = PW'(tmax) * PW'(ady);
  assign p_umin_d   = PW'(umin) * PW'(d);
  assign p_umax_d   = PW'(umax) * PW'(d);

endmodule

FILE: sv/srht_decide.sv
// ----------------------------------------------------------------------------
// srht_decide
// Compares the cross products and combines them with the flags into hit.
// ----------------------------------------------------------------------------
module srht_decide #(
  parameter int W = srht_pkg::COORD_WIDTH
) (
  input  logic signed [2*W+3:0] p_ad,
  input  logic signed [2*W+3:0] p_bd,
  input  logic signed [2*W+3:0] p_dy_tmin,
  input  logic signed [2*W+3:0] p_dy_tmax,
  input  logic signed [2*W+3:0] p_tmin_ady,
  input  logic signed [2*W+3:0] p_tmax_ady,
  input  logic signed [2*W+3:0] p_umin_d,
  input  logic signed [2*W+3:0] p_umax_d,
  input  srht_pkg::flags_t      flags,
  output logic                  hit
);
  logic cv_min, cv_max, ch_min, ch_max, edge_cross;

  assign cv_min = flags.xmin_span && p_ad < p_dy_tmin && p_dy_tmin < p_bd;
  assign cv_max = flags.xmax_span && p_ad < p_dy_tmax && p_dy_tmax < p_bd;
  assign ch_min = flags.ymin_span && p_tmin_ady < p_umin_d && p_umin_d < p_tmax_ady;
  assign ch_max = flags.ymax_span && p_tmin_ady < p_umax_d && p_umax_d < p_tmax_ady;

  assign edge_cross = cv_min || cv_max || (flags.dy_nz && (ch_min || ch_max));
  assign hit        = flags.in_rect || (flags.vert ? flags.vert_hit : edge_cross);

endmodule

FILE: sv/segment_rectangle_hit_test_core.sv
// ----------------------------------------------------------------------------
// segment_rectangle_hit_test_core
// Throughput: one request per cycle while result.ready does not stall; the
// eight parallel cross-product multipliers and a four-stage register
// pipeline with per-stage ready set it.
// Reset: synchronous, clears stage valids and all four corner registers.
// ----------------------------------------------------------------------------
module segment_rectangle_hit_test_core #(
  parameter int COORD_WIDTH = srht_pkg::COORD_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  srht_seg_if.sink    seg,
  srht_cfg_if.sink    cfg,
  srht_hit_if.source  result
);
  localparam int W  = COORD_WIDTH;
  localparam int OW = W + 2;
  localparam int PW = 2 * W + 4;

  logic signed [W-1:0] corner_a_x, corner_a_y, corner_b_x, corner_b_y;
  logic signed [W-1:0] xmin, xmax, ymin, ymax;

  logic                v0, v1, v2, v3;
  logic                rdy0, rdy1, rdy2, rdy3;

  logic signed [W-1:0] x0, y0, x1, y1;

  logic signed [OW-1:0] d_next, dy_next, a_next, b_next, tmin_next, tmax_next;
  logic signed [OW-1:0] ady_next, umin_next, umax_next;
  srht_pkg::flags_t     flags_next;
  logic signed [OW-1:0] d, dy, a, b, tmin, tmax, ady, umin, umax;
  srht_pkg::flags_t     flags1;

  logic signed [PW-1:0] p_ad_next, p_bd_next, p_dy_tmin_next, p_dy_tmax_next;
  logic signed [PW-1:0] p_tmin_ady_next, p_tmax_ady_next, p_umin_d_next, p_umax_d_next;
  logic signed [PW-1:0] p_ad, p_bd, p_dy_tmin, p_dy_tmax;
  logic signed [PW-1:0] p_tmin_ady, p_tmax_ady, p_umin_d, p_umax_d;
  srht_pkg::flags_t     flags2;

  logic                 hit_next;
  logic                 hit;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_a_x <= '0;
      corner_a_y <= '0;
      corner_b_x <= '0;
      corner_b_y <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        srht_pkg::REG_CORNER_A_X: corner_a_x <= cfg.data;
        srht_pkg::REG_CORNER_A_Y: corner_a_y <= cfg.data;
        srht_pkg::REG_CORNER_B_X: corner_b_x <= cfg.data;
        srht_pkg::REG_CORNER_B_Y: corner_b_y <= cfg.data;
        default: ;
      endcase
    end
  end

  assign xmin = (corner_a_x < corner_b_x) ? corner_a_x : corner_b_x;
  assign xmax = (corner_a_x < corner_b_x) ? corner_b_x : corner_a_x;
  assign ymin = (corner_a_y < corner_b_y) ? corner_a_y : corner_b_y;
  assign ymax = (corner_a_y < corner_b_y) ? corner_b_y : corner_a_y;

  // stage handshake
  assign rdy3      = !v3 || result.ready;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign rdy0      = !v0 || rdy1;
  assign seg.ready = rdy0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy0) v0 <= seg.valid;
      if (rdy1) v1 <= v0;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rdy0 && seg.valid) begin
      x0 <= seg.start_x;
      y0 <= seg.start_y;
      x1 <= seg.end_x;
      y1 <= seg.end_y;
    end
  end

  srht_prep #(.W(W)) u_prep (
    .x0    (x0),
    .y0    (y0),
    .x1    (x1),
    .y1    (y1),
    .xmin  (xmin),
    .xmax  (xmax),
    .ymin  (ymin),
    .ymax  (ymax),
    .d     (d_next),
    .dy    (dy_next),
    .a     (a_next),
    .b     (b_next),
    .tmin  (tmin_next),
    .tmax  (tmax_next),
    .ady   (ady_next),
    .umin  (umin_next),
    .umax  (umax_next),
    .flags (flags_next)
  );

  always_ff @(posedge clk) begin
    if (rdy1 && v0) begin
      d      <= d_next;
      dy     <= dy_next;
      a      <= a_next;
      b      <= b_next;
      tmin   <= tmin_next;
      tmax   <= tmax_next;
      ady    <= ady_next;
      umin   <= umin_next;
      umax   <= umax_next;
      flags1 <= flags_next;
    end
  end

  srht_prod #(.W(W)) u_prod (
    .d          (d),
    .dy         (dy),
    .a          (a),
    .b          (b),
    .tmin       (tmin),
    .tmax       (tmax),
    .ady        (ady),
    .umin       (umin),
    .umax       (umax),
    .p_ad       (p_ad_next),
    .p_bd       (p_bd_next),
    .p_dy_tmin  (p_dy_tmin_next),
    .p_dy_tmax  (p_dy_tmax_next),
    .p_tmin_ady (p_tmin_ady_next),
    .p_tmax_ady (p_tmax_ady_next),
    .p_umin_d   (p_umin_d_next),
    .p_umax_d   (p_umax_d_next)
  );

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      p_ad       <= p_ad_next;
      p_bd       <= p_bd_next;
      p_dy_tmin  <= p_dy_tmin_next;
      p_dy_tmax  <= p_dy_tmax_next;
      p_tmin_ady <= p_tmin_ady_next;
      p_tmax_ady <= p_tmax_ady_next;
      p_umin_d   <= p_umin_d_next;
      p_umax_d   <= p_umax_d_next;
      flags2     <= flags1;
    end
  end

  srht_decide #(.W(W)) u_decide (
    .p_ad       (p_ad),
    .p_bd       (p_bd),
    .p_dy_tmin  (p_dy_tmin),
    .p_dy_tmax  (p_dy_tmax),
    .p_tmin_ady (p_tmin_ady),
    .p_tmax_ady (p_tmax_ady),
    .p_umin_d   (p_umin_d),
    .p_umax_d   (p_umax_d),
    .flags      (flags2),
    .hit        (hit_next)
  );

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      hit <= hit_next;
    end
  end

  assign result.valid = v3;
  assign result.hit   = hit;

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for segment_rectangle_hit_test_core. A driver feeds
// segment requests from a queue, a monitor checks each hit bit against an
// exact cross-multiplied hit predictor, and the rectangle corners are
// rewritten between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int W = srht_pkg::COORD_WIDTH;
  localparam logic signed [W-1:0] COORD_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] COORD_MAX = {1'b0, {(W-1){1'b1}}};
  localparam longint LMIN = COORD_MIN;
  localparam longint LMAX = COORD_MAX;
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    logic signed [W-1:0] start_x;
    logic signed [W-1:0] start_y;
    logic signed [W-1:0] end_x;
    logic signed [W-1:0] end_y;
  } segment_t;

  typedef struct {
    segment_t seg;
    logic     hit;
  } hit_entry_t;

  logic clk = 1'b0;
  logic rst;

  srht_seg_if #(.W(W)) seg_ch ();
  srht_cfg_if #(.W(W)) cfg_ch ();
  srht_hit_if          hit_ch ();

  segment_rectangle_hit_test_core #(.COORD_WIDTH(W)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .seg    (seg_ch),
    .cfg    (cfg_ch),
    .result (hit_ch)
  );

  segment_t            pending_segs[$];
  hit_entry_t          expected_hits[$];
  segment_t            next_seg;
  hit_entry_t          got_entry;
  hit_entry_t          exp_entry;
  logic signed [W-1:0] rect_ax = '0;
  logic signed [W-1:0] rect_ay = '0;
  logic signed [W-1:0] rect_bx = '0;
  logic signed [W-1:0] rect_by = '0;
  int                  idle_pct = 37;
  int                  mismatches = 0;
  int                  stall_cycles = 0;

  always #4 clk = ~clk;

  function automatic longint lmin(longint a, longint b);
    return a < b ? a : b;
  endfunction

  function automatic longint lmax(longint a, longint b);
    return a > b ? a : b;
  endfunction

  // a*b < c*d at full precision
  function automatic bit prod_lt(longint a, longint b, longint c, longint d);
    logic signed [127:0] p;
    logic signed [127:0] q;
    p = a * b;
    q = c * d;
    return p < q;
  endfunction

  function automatic bit in_rect(longint x, longint y, longint xmin, longint xmax,
                                 longint ymin, longint ymax);
    return x >= xmin && x <= xmax && y >= ymin && y <= ymax;
  endfunction

  // segment with x0 < x0 + dx crosses x = lx strictly inside ymin..ymax
  function automatic bit crosses_x_line(longint x0, longint y0, longint dx, longint dy,
                                        longint lx, longint ymin, longint ymax);
    longint t;
    if (lx < x0 || lx > x0 + dx) return 1'b0;
    t = lx - x0;
    return prod_lt(ymin - y0, dx, dy, t) && prod_lt(dy, t, ymax - y0, dx);
  endfunction

  // segment crosses y = ly strictly inside xmin..xmax, dy nonzero
  function automatic bit crosses_y_line(longint x0, longint y0, longint dx, longint dy,
                                        longint ly, longint xmin, longint xmax);
    longint u;
    u = ly - y0;
    if (ly < lmin(y0, y0 + dy) || ly > lmax(y0, y0 + dy)) return 1'b0;
    if (dy < 0) begin
      dy = -dy;
      u  = -u;
    end
    return prod_lt(xmin - x0, dy, u, dx) && prod_lt(u, dx, xmax - x0, dy);
  endfunction

  function automatic logic predict_hit(segment_t s);
    longint x0, y0, x1, y1, xmin, xmax, ymin, ymax, dx, dy, tmp;
    bit h;
    x0   = s.start_x;
    y0   = s.start_y;
    x1   = s.end_x;
    y1   = s.end_y;
    xmin = lmin(rect_ax, rect_bx);
    xmax = lmax(rect_ax, rect_bx);
    ymin = lmin(rect_ay, rect_by);
    ymax = lmax(rect_ay, rect_by);
    h = in_rect(x0, y0, xmin, xmax, ymin, ymax) || in_rect(x1, y1, xmin, xmax, ymin, ymax);
    if (!h && x0 == x1) begin
      h = x0 > xmin && x0 < xmax && lmin(y0, y1) <= ymax && lmax(y0, y1) >= ymin;
    end else if (!h) begin
      if (x1 < x0) begin
        tmp = x0; x0 = x1; x1 = tmp;
        tmp = y0; y0 = y1; y1 = tmp;
      end
      dx = x1 - x0;
      dy = y1 - y0;
      h = crosses_x_line(x0, y0, dx, dy, xmin, ymin, ymax) ||
          crosses_x_line(x0, y0, dx, dy, xmax, ymin, ymax);
      if (!h && dy != 0)
        h = crosses_y_line(x0, y0, dx, dy, ymin, xmin, xmax) ||
            crosses_y_line(x0, y0, dx, dy, ymax, xmin, xmax);
    end
    return h;
  endfunction

  function automatic logic signed [W-1:0] fx(int v);
    return W'(longint'(v) * 65536);
  endfunction

  function automatic logic signed [W-1:0] pick_coord(longint lo, longint hi);
    longint unsigned r;
    longint v, span;
    r    = {$urandom, $urandom};
    span = hi - lo + 1;
    case ($urandom_range(0, 7))
      0, 1: return W'(r);
      2: v = lo;
      3: v = hi;
      4: v = lo + longint'(r % span);
      5: v = lo - 1 - longint'(r % span);
      6: v = hi + 1 + longint'(r % span);
      default: v = (r[0] ? lo : hi) + longint'($urandom_range(0, 2)) - 1;
    endcase
    if (v < LMIN) v = LMIN;
    if (v > LMAX) v = LMAX;
    return W'(v);
  endfunction

  task automatic add_seg(logic signed [W-1:0] sx, logic signed [W-1:0] sy,
                         logic signed [W-1:0] ex, logic signed [W-1:0] ey);
    segment_t s;
    s.start_x = sx;
    s.start_y = sy;
    s.end_x   = ex;
    s.end_y   = ey;
    pending_segs.push_back(s);
  endtask

  task automatic queue_random_segs(int count);
    longint xmin, xmax, ymin, ymax;
    logic signed [W-1:0] sx, sy, ex, ey;
    xmin = lmin(rect_ax, rect_bx);
    xmax = lmax(rect_ax, rect_bx);
    ymin = lmin(rect_ay, rect_by);
    ymax = lmax(rect_ay, rect_by);
    repeat (count) begin
      sx = pick_coord(xmin, xmax);
      sy = pick_coord(ymin, ymax);
      ex = pick_coord(xmin, xmax);
      ey = pick_coord(ymin, ymax);
      case ($urandom_range(0, 9))
        6, 7: ex = sx;
        8: ey = sy;
        9: begin
          ex = sx;
          ey = sy;
        end
        default: ;
      endcase
      add_seg(sx, sy, ex, ey);
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_segs.size() != 0 || seg_ch.valid || expected_hits.size() != 0);
  endtask

  task automatic write_reg(logic [srht_pkg::CFG_IDX_W-1:0] idx, logic [W-1:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic write_corners(logic [W-1:0] ax, logic [W-1:0] ay,
                               logic [W-1:0] bx, logic [W-1:0] by);
    write_reg(srht_pkg::REG_CORNER_A_X, ax);
    write_reg(srht_pkg::REG_CORNER_A_Y, ay);
    write_reg(srht_pkg::REG_CORNER_B_X, bx);
    write_reg(srht_pkg::REG_CORNER_B_Y, by);
    @(negedge clk);
  endtask

  function automatic logic [W-1:0] random_corner();
    if ($urandom_range(0, 3) == 0) return W'({$urandom, $urandom});
    return fx(int'($urandom_range(0, 80)) - 40) + W'($urandom_range(0, 65535));
  endfunction

  // segment driver; records the expected hit at each accepted request
  always @(posedge clk) begin
    if (rst) begin
      seg_ch.valid   <= 1'b0;
      seg_ch.start_x <= '0;
      seg_ch.start_y <= '0;
      seg_ch.end_x   <= '0;
      seg_ch.end_y   <= '0;
    end else begin
      if (seg_ch.valid && seg_ch.ready) begin
        got_entry.seg.start_x = seg_ch.start_x;
        got_entry.seg.start_y = seg_ch.start_y;
        got_entry.seg.end_x   = seg_ch.end_x;
        got_entry.seg.end_y   = seg_ch.end_y;
        got_entry.hit         = predict_hit(got_entry.seg);
        expected_hits.push_back(got_entry);
      end
      if (!seg_ch.valid || seg_ch.ready) begin
        if (pending_segs.size() != 0 && $urandom_range(99) >= idle_pct) begin
          next_seg = pending_segs.pop_front();
          seg_ch.valid   <= 1'b1;
          seg_ch.start_x <= next_seg.start_x;
          seg_ch.start_y <= next_seg.start_y;
          seg_ch.end_x   <= next_seg.end_x;
          seg_ch.end_y   <= next_seg.end_y;
        end else begin
          seg_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    hit_ch.ready <= rst ? 1'b0 : ($urandom_range(99) >= idle_pct);
  end

  // corner shadow, result check and stall counter
  always @(posedge clk) begin
    if (!rst && cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        srht_pkg::REG_CORNER_A_X: rect_ax <= cfg_ch.data;
        srht_pkg::REG_CORNER_A_Y: rect_ay <= cfg_ch.data;
        srht_pkg::REG_CORNER_B_X: rect_bx <= cfg_ch.data;
        srht_pkg::REG_CORNER_B_Y: rect_by <= cfg_ch.data;
        default: ;
      endcase
    end
    if (!rst && hit_ch.valid && hit_ch.ready) begin
      if (expected_hits.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual hit=%0b", $time, hit_ch.hit);
      end else begin
        exp_entry = expected_hits.pop_front();
        if (hit_ch.hit !== exp_entry.hit) begin
          mismatches++;
          $display("%0t: hit mismatch (%0d,%0d)->(%0d,%0d) expected %0b actual %0b",
                   $time, exp_entry.seg.start_x, exp_entry.seg.start_y,
                   exp_entry.seg.end_x, exp_entry.seg.end_y, exp_entry.hit, hit_ch.hit);
        end
      end
    end
    if (rst || (seg_ch.valid && seg_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
        (hit_ch.valid && hit_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(negedge clk);
    $display("** segment_rectangle_hit_test_core: FAILED **");
    $finish;
  end

  initial begin
    rst            = 1'b1;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = '0;
    cfg_ch.data    = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // point rectangle at the origin after reset
    add_seg(fx(0), fx(0), fx(0), fx(0));
    add_seg(fx(-1), fx(0), fx(1), fx(0));
    add_seg(fx(0), fx(-1), fx(0), fx(1));
    add_seg(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    queue_random_segs(150);
    wait_idle();

    // corners given in reversed order: x -3..10, y -5..7
    write_corners(fx(10), fx(-5), fx(-3), fx(7));
    add_seg(fx(0), fx(0), fx(100), fx(100));
    add_seg(fx(100), fx(100), fx(0), fx(0));
    add_seg(fx(2), fx(-20), fx(2), fx(20));
    add_seg(fx(-3), fx(-20), fx(-3), fx(20));
    add_seg(fx(2), fx(8), fx(2), fx(20));
    add_seg(fx(-20), fx(0), fx(20), fx(0));
    add_seg(fx(-20), fx(7), fx(20), fx(7));
    add_seg(fx(0), fx(-10), fx(4), fx(10));
    add_seg(fx(-8), fx(0), fx(2), fx(-10));
    add_seg(fx(12), fx(0), fx(20), fx(0));
    add_seg(fx(11), fx(-20), fx(12), fx(-30));
    add_seg(fx(0), fx(8), fx(1), fx(8));
    add_seg(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
    add_seg(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    add_seg(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    add_seg(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
    add_seg(COORD_MIN, fx(0), COORD_MAX, fx(0));
    queue_random_segs(300);
    wait_idle();

    // whole coordinate plane
    write_corners(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    queue_random_segs(150);
    wait_idle();

    // zero-width rectangle
    write_corners(fx(5), fx(-10), fx(5), fx(10));
    add_seg(fx(0), fx(0), fx(10), fx(0));
    queue_random_segs(200);
    wait_idle();

    // zero-height rectangle
    write_corners(fx(-10), fx(3), fx(10), fx(3));
    add_seg(fx(0), fx(-5), fx(0), fx(5));
    queue_random_segs(200);
    wait_idle();

    for (int ph = 0; ph < 5; ph++) begin
      write_corners(random_corner(), random_corner(), random_corner(), random_corner());
      idle_pct = (ph == 2) ? 0 : 37;
      queue_random_segs(170);
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_hits.size() == 0) begin
      $display("** segment_rectangle_hit_test_core: PASSED **");
    end else begin
      $display("** segment_rectangle_hit_test_core: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/srht_pkg.sv
sv/srht_seg_if.sv
sv/srht_hit_if.sv
sv/srht_cfg_if.sv
sv/srht_prep.sv
sv/srht_prod.sv
sv/srht_decide.sv
sv/segment_rectangle_hit_test_core.sv
dv/tb_top.sv
